// ----- src/v3u_pkg.sv -----
// v3u_pkg: shared types, action codes and the operand and result structs
// of the 3-component vector unit. No dependencies.
package v3u_pkg;

    typedef enum logic [3:0] {
        ACT_ADD  = 4'd0,
        ACT_SUB  = 4'd1,
        ACT_CROSS = 4'd2,
        ACT_SCALE = 4'd3,
        ACT_NEG  = 4'd4,
        ACT_DOT  = 4'd5,
        ACT_MAG  = 4'd6,
        ACT_DIST = 4'd7,
        ACT_NORM = 4'd8,
        ACT_EQ   = 4'd9,
        ACT_NE   = 4'd10,
        ACT_LT   = 4'd11,
        ACT_GT   = 4'd12,
        ACT_LE   = 4'd13,
        ACT_GE   = 4'd14,
        ACT_NONE = 4'd15
    } action_t;

    typedef struct packed {
        logic [3:0]         action;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] scale_factor;
    } req_t;

    typedef struct packed {
        logic signed [31:0] res_x;
        logic signed [31:0] res_y;
        logic signed [31:0] res_z;
        logic signed [47:0] res_scalar;
        logic               res_flag;
        logic               overflow;
        logic               zero_length;
    } rsp_t;

    localparam int SQ_W   = 66;  // squared magnitude of a 33-bit value; the sum of three uses SQ_W+2 bits
    localparam int ROOT_W = 34;  // floor sqrt of a value below 2^68

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -66'sh0_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic ovf32(input logic signed [65:0] v);
        return (v > 66'sh0_7FFF_FFFF) || (v < -66'sh0_8000_0000);
    endfunction

endpackage

// ----- src/v3u_stream_if.sv -----
// v3u_stream_if: valid/ready channel carrying one request or result.
// Depends on v3u_pkg only through the payload type parameter.
interface v3u_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/vec3_vector_unit.sv -----
// vec3_vector_unit: 3-component Q16.16 vector ALU, top level.
// Path: lane registers, then square root pipe, then divider pipe, then output register.
// Throughput: one request per cycle; the whole pipe advances whenever the
//   output register is empty or being taken, so a stall freezes every stage.
// Reset (rst_n, async low) clears only the valid bits; payload stages
//   hold whatever they had. No clearing pass.
// Depends on v3u_pkg, v3u_stream_if, v3u_lane, v3u_sqrt, v3u_div.
module vec3_vector_unit
    import v3u_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    v3u_stream_if.sink   req,
    v3u_stream_if.source rsp
);
    localparam int QW   = 56;
    localparam int LAT  = 1 + ROOT_W + QW;  // depth of the valid pipe ahead of the output register

    // Pipe advance: everything moves unless the output register is stuck.
    logic adv;
    assign adv = !rsp.valid || rsp.ready;
    assign req.ready = adv;

    logic [LAT-1:0] vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], req.valid};
    end

    // ---- Stage 0/1: three lanes doing products and sums ----
    req_t i;
    assign i = req.data;
    logic signed [31:0] av [3], bv [3];
    assign av[0] = i.a_x; assign av[1] = i.a_y; assign av[2] = i.a_z;
    assign bv[0] = i.b_x; assign bv[1] = i.b_y; assign bv[2] = i.b_z;

    logic signed [65:0] sum [3], dif [3], p0 [3], p1 [3];
    logic [SQ_W-1:0] qa [3], qb [3], qd [3];

    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        // cross: p0 = a[k+1]*b[k+2], p1 = a[k+2]*b[k+1]; otherwise the same muxes
        // give p0 = a[k]*b[k] for dot and p1 = a[k]*scale_factor for scale.
        localparam int K1 = (k + 1) % 3;
        localparam int K2 = (k + 2) % 3;
        logic signed [31:0] m0a, m0b, m1a, m1b;
        logic is_cross;
        assign is_cross = (i.action == ACT_CROSS);
        assign m0a = is_cross ? av[K1] : av[k];
        assign m0b = is_cross ? bv[K2] : bv[k];
        assign m1a = is_cross ? av[K2] : av[k];
        assign m1b = is_cross ? bv[K1] : i.scale_factor;
        v3u_lane u_lane (
            .clk(clk), .en(adv), .a(av[k]), .b(bv[k]),
            .m0a(m0a), .m0b(m0b), .m1a(m1a), .m1b(m1b),
            .sum_ab(sum[k]), .dif_ab(dif[k]), .prod0(p0[k]), .prod1(p1[k]),
            .sq_a(qa[k]), .sq_b(qb[k]), .sq_d(qd[k]));
    end

    // action and a-vector registered to line up with lane outputs
    logic [3:0] act1_reg;
    logic signed [31:0] a1_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            act1_reg <= i.action;
            for (int k = 0; k < 3; k++)
                a1_reg[k] <= av[k];
        end
    end

    // ---- Merge stage: build vector/scalar/flag, pick sqrt radicand ----
    rsp_t m;
    logic [SQ_W+1:0] sa, sb, sd, rad;
    logic signed [65:0] vr [3];
    logic signed [65:0] dsum;
    logic ov;
    assign sa = (SQ_W+2)'(qa[0]) + (SQ_W+2)'(qa[1]) + (SQ_W+2)'(qa[2]);
    assign sb = (SQ_W+2)'(qb[0]) + (SQ_W+2)'(qb[1]) + (SQ_W+2)'(qb[2]);
    assign sd = (SQ_W+2)'(qd[0]) + (SQ_W+2)'(qd[1]) + (SQ_W+2)'(qd[2]);
    assign dsum = (p0[0] + p0[1] + p0[2]) >>> FRAC_BITS;

    always_comb
    begin
        m   = '0;
        ov  = 1'b0;
        rad = sa;
        for (int k = 0; k < 3; k++)
            vr[k] = '0;
        unique case (act1_reg)
            ACT_ADD:   for (int k = 0; k < 3; k++) vr[k] = sum[k];
            ACT_SUB:   for (int k = 0; k < 3; k++) vr[k] = dif[k];
            ACT_CROSS: for (int k = 0; k < 3; k++) vr[k] = (p0[k] - p1[k]) >>> FRAC_BITS;
            ACT_SCALE: for (int k = 0; k < 3; k++) vr[k] = p1[k] >>> FRAC_BITS;
            ACT_NEG:   for (int k = 0; k < 3; k++) vr[k] = -66'(a1_reg[k]);
            ACT_DOT:
            begin
                if (dsum > 66'sh0_7FFF_FFFF_FFFF)
                begin
                    m.res_scalar = 48'sh7FFF_FFFF_FFFF; ov = 1'b1;
                end
                else if (dsum < -66'sh0_8000_0000_0000)
                begin
                    m.res_scalar = 48'sh8000_0000_0000; ov = 1'b1;
                end
                else
                    m.res_scalar = dsum[47:0];
            end
            ACT_MAG, ACT_NORM: rad = sa;
            ACT_DIST:  rad = sd;
            ACT_EQ:    m.res_flag = (dif[0] == 0) && (dif[1] == 0) && (dif[2] == 0);
            ACT_NE:    m.res_flag = (dif[0] != 0) || (dif[1] != 0) || (dif[2] != 0);
            ACT_LT:    m.res_flag = sa < sb;
            ACT_GT:    m.res_flag = sa > sb;
            ACT_LE:    m.res_flag = sa <= sb;
            ACT_GE:    m.res_flag = sa >= sb;
            default:   m = '0;
        endcase
        m.res_x = sat32(vr[0]);
        m.res_y = sat32(vr[1]);
        m.res_z = sat32(vr[2]);
        m.overflow = ov || ovf32(vr[0]) || ovf32(vr[1]) || ovf32(vr[2]);
        if (act1_reg == ACT_NORM)
            m.zero_length = (sa == '0);
    end

    // ---- Square root, with the merged result riding as a tag ----
    localparam int TAG_W = $bits(rsp_t) + 4 + 96;
    logic [TAG_W-1:0] sq_tag;
    logic [TAG_W-1:0] sq_out;
    logic [ROOT_W-1:0] root;
    assign sq_tag = {m, act1_reg, a1_reg[0], a1_reg[1], a1_reg[2]};
    v3u_sqrt #(.TAG_W(TAG_W)) u_sqrt (
        .clk(clk), .en(adv), .rad(rad), .tag_in(sq_tag),
        .root(root), .tag_out(sq_out));

    // a-vector out of the tag, low 96 bits
    logic signed [31:0] a2 [3];
    assign a2[0] = sq_out[95:64];
    assign a2[1] = sq_out[63:32];
    assign a2[2] = sq_out[31:0];

    // ---- Normalize: three lane dividers on |a| << FRAC_BITS / root ----
    logic [QW-1:0] quo [3];
    logic [ROOT_W-1:0] den;
    assign den = (root == '0) ? ROOT_W'(1) : root;
    for (genvar k = 0; k < 3; k++)
    begin : g_div
        logic [31:0] amag;
        assign amag = a2[k][31] ? 32'(-a2[k]) : a2[k];
        v3u_div #(.NW(QW), .DW(ROOT_W), .QW(QW)) u_div (
            .clk(clk), .en(adv),
            .num(QW'({amag, FRAC_BITS'(0)})), .den(den), .quo(quo[k]));
    end

    // delay line for the merged result across the divider
    logic [TAG_W+ROOT_W-1:0] dl_reg [QW];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dl_reg[0] <= {sq_out, root};
            for (int s = 1; s < QW; s++)
                dl_reg[s] <= dl_reg[s-1];
        end
    end

    rsp_t m3, fin;
    logic [3:0] act3;
    logic signed [31:0] a3 [3];
    logic [ROOT_W-1:0] root3;
    assign {m3, act3, a3[0], a3[1], a3[2], root3} = dl_reg[QW-1];

    always_comb
    begin
        fin = m3;
        if (act3 == ACT_MAG || act3 == ACT_DIST)
            fin.res_scalar = 48'(root3);
        else if (act3 == ACT_NORM && !m3.zero_length)
        begin
            fin.res_x = a3[0][31] ? -32'(quo[0]) : 32'(quo[0]);
            fin.res_y = a3[1][31] ? -32'(quo[1]) : 32'(quo[1]);
            fin.res_z = a3[2][31] ? -32'(quo[2]) : 32'(quo[2]);
        end
    end

    // ---- Output register ----
    logic out_vld_reg;
    rsp_t out_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= vld_reg[LAT-1];
    end
    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= fin;
    end
    assign rsp.valid = out_vld_reg;
    assign rsp.data  = out_reg;

    // Assertions
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
        else $error("result changed while stalled");
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |-> !req.ready)
        else $error("accepted while output stalled");
    a_zl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.zero_length |-> rsp.data.res_scalar == '0)
        else $error("zero_length with scalar result");
endmodule

// ----- src/v3u_lane.sv -----
// v3u_lane: one component lane. Products, squares, sum and difference.
// Depends on v3u_pkg. Outputs are registered, with enable.
module v3u_lane
    import v3u_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    input  logic signed [31:0] m0a,
    input  logic signed [31:0] m0b,
    input  logic signed [31:0] m1a,
    input  logic signed [31:0] m1b,
    output logic signed [65:0] sum_ab,
    output logic signed [65:0] dif_ab,
    output logic signed [65:0] prod0,
    output logic signed [65:0] prod1,
    output logic [SQ_W-1:0]   sq_a,
    output logic [SQ_W-1:0]   sq_b,
    output logic [SQ_W-1:0]   sq_d
);
    logic signed [63:0] p0_reg, p1_reg;
    logic [63:0] qa_reg, qb_reg;
    logic [65:0] qd_reg;
    logic signed [32:0] d;
    logic [32:0] dm;
    logic [31:0] am, bm;
    logic signed [32:0] s_reg, df_reg;

    assign d  = 33'(a) - 33'(b);
    assign dm = d[32] ? 33'(-d) : d;
    assign am = a[31] ? 32'(-a) : a;
    assign bm = b[31] ? 32'(-b) : b;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg <= 64'(m0a) * 64'(m0b);
            p1_reg <= 64'(m1a) * 64'(m1b);
            qa_reg <= 64'(am) * 64'(am);
            qb_reg <= 64'(bm) * 64'(bm);
            qd_reg <= 66'(dm) * 66'(dm);
            s_reg  <= 33'(a) + 33'(b);
            df_reg <= d;
        end
    end

    assign sum_ab = 66'(s_reg);
    assign dif_ab = 66'(df_reg);
    assign prod0  = 66'(p0_reg);
    assign prod1  = 66'(p1_reg);
    assign sq_a   = SQ_W'(qa_reg);
    assign sq_b   = SQ_W'(qb_reg);
    assign sq_d   = SQ_W'(qd_reg);
endmodule

// ----- src/v3u_sqrt.sv -----
// v3u_sqrt: pipelined restoring square root, one result bit per stage.
// Depends on v3u_pkg. Carries a tag alongside the root.
module v3u_sqrt
    import v3u_pkg::*;
#(
    parameter int TAG_W = 8
)
(
    input  logic              clk,
    input  logic              en,
    input  logic [SQ_W+1:0]   rad,
    input  logic [TAG_W-1:0]  tag_in,
    output logic [ROOT_W-1:0] root,
    output logic [TAG_W-1:0]  tag_out
);
    logic [SQ_W+1:0]   rad_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [ROOT_W+1:0] rem_reg  [ROOT_W];
    logic [TAG_W-1:0]  tag_reg  [ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++)
    begin : g_stage
        logic [SQ_W+1:0]   r_in;
        logic [ROOT_W-1:0] q_in;
        logic [ROOT_W+1:0] m_in;
        logic [TAG_W-1:0]  t_in;
        logic [ROOT_W+3:0] rm, tr;
        if (s == 0)
        begin : g_first
            assign r_in = rad;
            assign q_in = '0;
            assign m_in = '0;
            assign t_in = tag_in;
        end
        else
        begin : g_next
            assign r_in = rad_reg[s-1];
            assign q_in = root_reg[s-1];
            assign m_in = rem_reg[s-1];
            assign t_in = tag_reg[s-1];
        end
        assign rm = {m_in, r_in[SQ_W+1 -: 2]};
        assign tr = {2'b00, q_in, 2'b01};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[s] <= {r_in[SQ_W-1:0], 2'b00};
                tag_reg[s] <= t_in;
                if (rm >= tr)
                begin
                    rem_reg[s]  <= (ROOT_W+2)'(rm - tr);
                    root_reg[s] <= {q_in[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s]  <= rm[ROOT_W+1:0];
                    root_reg[s] <= {q_in[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign root    = root_reg[ROOT_W-1];
    assign tag_out = tag_reg[ROOT_W-1];
endmodule

// ----- src/v3u_div.sv -----
// v3u_div: pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on nothing. Quotient is truncated.
module v3u_div #(
    parameter int NW = 56,
    parameter int DW = 34,
    parameter int QW = 56
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);
    logic [NW-1:0] n_reg [QW];
    logic [DW-1:0] d_reg [QW];
    logic [DW:0]   r_reg [QW];
    logic [QW-1:0] q_reg [QW];

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        logic [NW-1:0] n_in;
        logic [DW-1:0] d_in;
        logic [DW:0]   r_in;
        logic [QW-1:0] q_in;
        logic [DW+1:0] t;
        if (s == 0)
        begin : g_first
            assign n_in = num;
            assign d_in = den;
            assign r_in = '0;
            assign q_in = '0;
        end
        else
        begin : g_next
            assign n_in = n_reg[s-1];
            assign d_in = d_reg[s-1];
            assign r_in = r_reg[s-1];
            assign q_in = q_reg[s-1];
        end
        assign t = {r_in, n_in[NW-1]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[s] <= {n_in[NW-2:0], 1'b0};
                d_reg[s] <= d_in;
                if (t >= (DW+2)'(d_in))
                begin
                    r_reg[s] <= (DW+1)'(t - (DW+2)'(d_in));
                    q_reg[s] <= {q_in[QW-2:0], 1'b1};
                end
                else
                begin
                    r_reg[s] <= t[DW:0];
                    q_reg[s] <= {q_in[QW-2:0], 1'b0};
                end
            end
        end
    end

    assign quo = q_reg[QW-1];
endmodule
